>>> rtl/ctsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ctsa_pkg;

  localparam int TAG_W     = 10;
  localparam int CW        = 44;   // cordic x/y datapath, q.24 with growth
  localparam int ZW        = 33;   // cordic angle, 2^32 per turn
  localparam int STAGES    = 24;
  localparam int NW        = 31;   // normalized component / root width
  localparam int SQW       = 63;   // sqrt remainder and root width
  localparam int SQ_CELLS  = 32;
  localparam int RW        = 48;   // divider remainder width
  localparam int QW        = 17;   // quotient magnitude width
  localparam int DIV_CELLS = 17;
  localparam int PTW       = 38;   // proportional term width
  localparam int LATENCY   = 1 + STAGES + 3 + SQ_CELLS + DIV_CELLS + 2;

  localparam logic [15:0] INV_K       = 16'd39797;
  localparam logic [15:0] P_GAIN_INIT = 16'd7864;
  localparam logic [15:0] D_GAIN_INIT = 16'd6554;

  localparam logic [1:0] REG_P_GAIN = 2'd0;
  localparam logic [1:0] REG_D_GAIN = 2'd1;

  typedef struct packed {
    logic [TAG_W-1:0]      tag;
    logic signed [PTW-1:0] pterm;
    logic                  qneg;
    logic                  zero;
    logic [NW-1:0]         ymag;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_of(input logic [4:0] k);
    logic signed [ZW-1:0] a;
    unique case (k)
      5'd0:    a = 33'sd536870912;
      5'd1:    a = 33'sd316933406;
      5'd2:    a = 33'sd167458907;
      5'd3:    a = 33'sd85004756;
      5'd4:    a = 33'sd42667331;
      5'd5:    a = 33'sd21354465;
      5'd6:    a = 33'sd10679838;
      5'd7:    a = 33'sd5340245;
      5'd8:    a = 33'sd2670163;
      5'd9:    a = 33'sd1335087;
      5'd10:   a = 33'sd667544;
      5'd11:   a = 33'sd333772;
      5'd12:   a = 33'sd166886;
      5'd13:   a = 33'sd83443;
      5'd14:   a = 33'sd41722;
      5'd15:   a = 33'sd20861;
      5'd16:   a = 33'sd10430;
      5'd17:   a = 33'sd5215;
      5'd18:   a = 33'sd2608;
      5'd19:   a = 33'sd1304;
      5'd20:   a = 33'sd652;
      5'd21:   a = 33'sd326;
      5'd22:   a = 33'sd163;
      5'd23:   a = 33'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ctsa_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ctsa_cordic_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [4:0]                         k,
  input  wire logic                               v_in,
  input  wire logic signed [ctsa_pkg::CW-1:0]     x_in,
  input  wire logic signed [ctsa_pkg::CW-1:0]     y_in,
  input  wire logic signed [ctsa_pkg::ZW-1:0]     z_in,
  input  wire logic [ctsa_pkg::TAG_W-1:0]         tag_in,
  output logic                                    v_out,
  output logic signed [ctsa_pkg::CW-1:0]          x_out,
  output logic signed [ctsa_pkg::CW-1:0]          y_out,
  output logic signed [ctsa_pkg::ZW-1:0]          z_out,
  output logic [ctsa_pkg::TAG_W-1:0]              tag_out
);

  logic signed [ctsa_pkg::CW-1:0] xs;
  logic signed [ctsa_pkg::CW-1:0] ys;
  logic signed [ctsa_pkg::ZW-1:0] ang;

  always_comb begin
    xs  = x_in >>> k;
    ys  = y_in >>> k;
    ang = ctsa_pkg::atan_of(k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    tag_out <= tag_in;
    if (!z_in[ctsa_pkg::ZW-1]) begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - ang;
    end else begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + ang;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ctsa_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ctsa_sqrt_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [4:0]                   k,
  input  wire logic                         v_in,
  input  wire logic [ctsa_pkg::SQW-1:0]     rem_in,
  input  wire logic [ctsa_pkg::SQW-1:0]     root_in,
  input  wire ctsa_pkg::side_t              side_in,
  output logic                              v_out,
  output logic [ctsa_pkg::SQW-1:0]          rem_out,
  output logic [ctsa_pkg::SQW-1:0]          root_out,
  output ctsa_pkg::side_t                   side_out
);

  logic [ctsa_pkg::SQW-1:0] bitv;
  logic [ctsa_pkg::SQW:0]   trial;

  always_comb begin
    bitv  = ctsa_pkg::SQW'(1) << {k, 1'b0};
    trial = {1'b0, root_in} + {1'b0, bitv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    side_out <= side_in;
    if ({1'b0, rem_in} >= trial) begin
      rem_out  <= rem_in - trial[ctsa_pkg::SQW-1:0];
      root_out <= (root_in >> 1) + bitv;
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in >> 1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ctsa_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ctsa_div_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [4:0]                  k,
  input  wire logic                        v_in,
  input  wire logic [ctsa_pkg::RW-1:0]     rem_in,
  input  wire logic [ctsa_pkg::NW-1:0]     den_in,
  input  wire logic [ctsa_pkg::QW-1:0]     q_in,
  input  wire ctsa_pkg::side_t             side_in,
  output logic                             v_out,
  output logic [ctsa_pkg::RW-1:0]          rem_out,
  output logic [ctsa_pkg::NW-1:0]          den_out,
  output logic [ctsa_pkg::QW-1:0]          q_out,
  output ctsa_pkg::side_t                  side_out
);

  logic [ctsa_pkg::RW-1:0] dsh;
  logic [ctsa_pkg::QW-1:0] qbit;

  always_comb begin
    dsh  = {{(ctsa_pkg::RW-ctsa_pkg::NW){1'b0}}, den_in} << k;
    qbit = ctsa_pkg::QW'(1) << k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    side_out <= side_in;
    den_out  <= den_in;
    if (rem_in >= dsh) begin
      rem_out <= rem_in - dsh;
      q_out   <= q_in | qbit;
    end else begin
      rem_out <= rem_in;
      q_out   <= q_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cross_track_steering_angle_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Cross-track steering controller. One request is taken in every clock cycle (busy stays low)
// and its result appears at the end of the pipeline, for one cycle, with result_valid high; the
// receiver cannot stall, so it must take each result in that cycle. The latency is set by
// the row of 24 cordic rotation cells, 32 square-root cells and 17 divider cells, plus the
// input, multiply, sum-of-squares, divider-input and output registers. Gains are written
// through the cfg port; write them only while no request is in flight.
module cross_track_steering_angle_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [9:0]                    agent_tag,
  input  wire logic signed [31:0]            target_x,
  input  wire logic signed [31:0]            target_y,
  input  wire logic signed [31:0]            current_x,
  input  wire logic signed [31:0]            current_y,
  input  wire logic [15:0]                   heading,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_data,
  output logic                               result_valid,
  output logic [9:0]                         result_tag,
  output logic signed [31:0]                 steer_cmd
);

  localparam int CW  = ctsa_pkg::CW;
  localparam int ZW  = ctsa_pkg::ZW;
  localparam int NW  = ctsa_pkg::NW;
  localparam int SQW = ctsa_pkg::SQW;
  localparam int RW  = ctsa_pkg::RW;
  localparam int QW  = ctsa_pkg::QW;
  localparam int PTW = ctsa_pkg::PTW;
  localparam int NS  = ctsa_pkg::STAGES;
  localparam int NQ  = ctsa_pkg::SQ_CELLS;
  localparam int ND  = ctsa_pkg::DIV_CELLS;

  logic [15:0] p_gain;
  logic [15:0] d_gain;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain <= ctsa_pkg::P_GAIN_INIT;
      d_gain <= ctsa_pkg::D_GAIN_INIT;
    end else if (cfg_valid) begin
      if (cfg_index == ctsa_pkg::REG_P_GAIN) begin
        p_gain <= cfg_data;
      end else if (cfg_index == ctsa_pkg::REG_D_GAIN) begin
        d_gain <= cfg_data;
      end
    end
  end

  // input stage: error vector in q.24 and half-turn pre-rotation
  logic signed [32:0]   dx;
  logic signed [32:0]   dy;
  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  logic signed [ZW-1:0] ze;
  logic signed [CW-1:0] x_next;
  logic signed [CW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  always_comb begin
    dx = {target_x[31], target_x} - {current_x[31], current_x};
    dy = {target_y[31], target_y} - {current_y[31], current_y};
    xe = {{3{dx[32]}}, dx, 8'b0};
    ye = {{3{dy[32]}}, dy, 8'b0};
    ze = {heading[15], heading, 16'b0};
    x_next = xe;
    y_next = ye;
    z_next = ze;
    if (heading[15:14] == 2'b01) begin
      x_next = -xe;
      y_next = -ye;
      z_next = ze - 33'sh080000000;
    end else if (heading[15:14] == 2'b10) begin
      x_next = -xe;
      y_next = -ye;
      z_next = ze + 33'sh080000000;
    end
  end

  logic                           cv   [0:NS];
  logic signed [CW-1:0]           cx   [0:NS];
  logic signed [CW-1:0]           cy   [0:NS];
  logic signed [ZW-1:0]           cz   [0:NS];
  logic [ctsa_pkg::TAG_W-1:0]     ctag [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    cx[0]   <= x_next;
    cy[0]   <= y_next;
    cz[0]   <= z_next;
    ctag[0] <= agent_tag;
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    ctsa_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .k       (5'(i)),
      .v_in    (cv[i]),
      .x_in    (cx[i]),
      .y_in    (cy[i]),
      .z_in    (cz[i]),
      .tag_in  (ctag[i]),
      .v_out   (cv[i+1]),
      .x_out   (cx[i+1]),
      .y_out   (cy[i+1]),
      .z_out   (cz[i+1]),
      .tag_out (ctag[i+1])
    );
  end

  // stage a: cross-track product and common normalizing shift
  logic [CW-1:0]        ax;
  logic [CW-1:0]        ay;
  logic [CW-1:0]        am;
  logic [3:0]           nsh;
  logic signed [CW-1:0] xsh;
  logic signed [CW-1:0] ysh;

  always_comb begin
    ax  = cx[NS][CW-1] ? CW'(-cx[NS]) : CW'(cx[NS]);
    ay  = cy[NS][CW-1] ? CW'(-cy[NS]) : CW'(cy[NS]);
    am  = (ax > ay) ? ax : ay;
    nsh = 4'd0;
    for (int j = 30; j < CW; j++) begin
      if (am[j]) begin
        nsh = 4'(j - 29);
      end
    end
    xsh = cx[NS] >>> nsh;
    ysh = cy[NS] >>> nsh;
  end

  logic                       a_v;
  logic signed [60:0]         a_ctp;
  logic signed [NW-1:0]       a_xs;
  logic signed [NW-1:0]       a_ys;
  logic                       a_xneg;
  logic                       a_zero;
  logic [ctsa_pkg::TAG_W-1:0] a_tag;

  always_ff @(posedge clk) begin
    a_ctp  <= cy[NS] * $signed({1'b0, ctsa_pkg::INV_K});
    a_xs   <= xsh[NW-1:0];
    a_ys   <= ysh[NW-1:0];
    a_xneg <= cx[NS][CW-1];
    a_zero <= (cx[NS] == '0) && (cy[NS] == '0);
    a_tag  <= ctag[NS];
  end

  // stage b: proportional product and squares
  logic signed [44:0]         ct;
  logic                       b_v;
  logic signed [61:0]         b_pprod;
  logic signed [61:0]         b_sx;
  logic signed [61:0]         b_sy;
  logic [NW-1:0]              b_ymag;
  logic                       b_qneg;
  logic                       b_zero;
  logic [ctsa_pkg::TAG_W-1:0] b_tag;

  assign ct = a_ctp[60:16];

  always_ff @(posedge clk) begin
    b_pprod <= ct * $signed({1'b0, p_gain});
    b_sx    <= a_xs * a_xs;
    b_sy    <= a_ys * a_ys;
    b_ymag  <= a_ys[NW-1] ? NW'(-a_ys) : NW'(a_ys);
    b_qneg  <= a_ys[NW-1] ^ a_xneg;
    b_zero  <= a_zero;
    b_tag   <= a_tag;
  end

  // stage c: sum of squares into the root chain
  logic                 sv   [0:NQ];
  logic [SQW-1:0]       srem [0:NQ];
  logic [SQW-1:0]       sroot[0:NQ];
  ctsa_pkg::side_t      sside[0:NQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v   <= 1'b0;
      b_v   <= 1'b0;
      sv[0] <= 1'b0;
    end else begin
      a_v   <= cv[NS];
      b_v   <= a_v;
      sv[0] <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    srem[0]        <= SQW'(b_sx[60:0]) + SQW'(b_sy[60:0]);
    sroot[0]       <= '0;
    sside[0].tag   <= b_tag;
    sside[0].pterm <= b_pprod[61:24];
    sside[0].qneg  <= b_qneg;
    sside[0].zero  <= b_zero;
    sside[0].ymag  <= b_ymag;
  end

  for (genvar i = 0; i < NQ; i++) begin : g_sqrt
    ctsa_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .k        (5'(NQ - 1 - i)),
      .v_in     (sv[i]),
      .rem_in   (srem[i]),
      .root_in  (sroot[i]),
      .side_in  (sside[i]),
      .v_out    (sv[i+1]),
      .rem_out  (srem[i+1]),
      .root_out (sroot[i+1]),
      .side_out (sside[i+1])
    );
  end

  // divider: |y| * 2^16 / norm, one quotient bit per cell
  logic                 dv   [0:ND];
  logic [RW-1:0]        drem [0:ND];
  logic [NW-1:0]        dden [0:ND];
  logic [QW-1:0]        dq   [0:ND];
  ctsa_pkg::side_t      dside[0:ND];
  logic [NW-1:0]        nroot;

  assign nroot = sroot[NQ][NW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= sv[NQ];
    end
  end

  always_ff @(posedge clk) begin
    drem[0]  <= {{(RW-NW-16){1'b0}}, sside[NQ].ymag, 16'b0};
    dden[0]  <= (nroot == '0) ? NW'(1) : nroot;
    dq[0]    <= '0;
    dside[0] <= sside[NQ];
  end

  for (genvar i = 0; i < ND; i++) begin : g_div
    ctsa_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .k        (5'(ND - 1 - i)),
      .v_in     (dv[i]),
      .rem_in   (drem[i]),
      .den_in   (dden[i]),
      .q_in     (dq[i]),
      .side_in  (dside[i]),
      .v_out    (dv[i+1]),
      .rem_out  (drem[i+1]),
      .den_out  (dden[i+1]),
      .q_out    (dq[i+1]),
      .side_out (dside[i+1])
    );
  end

  // stage d: signed sine and its product with d_gain
  logic signed [QW:0]         qs;
  logic                       d_v;
  logic signed [34:0]         d_prod;
  logic signed [PTW-1:0]      d_pterm;
  logic [ctsa_pkg::TAG_W-1:0] d_tag;

  always_comb begin
    if (dside[ND].zero) begin
      qs = '0;
    end else if (dside[ND].qneg) begin
      qs = -$signed({1'b0, dq[ND]});
    end else begin
      qs = $signed({1'b0, dq[ND]});
    end
  end

  always_ff @(posedge clk) begin
    d_prod  <= qs * $signed({1'b0, d_gain});
    d_pterm <= $signed(dside[ND].pterm);
    d_tag   <= dside[ND].tag;
  end

  // stage e: sum and saturate
  logic signed [18:0]  dterm;
  logic signed [PTW:0] sum;

  always_comb begin
    dterm = d_prod[34:16];
    sum   = {d_pterm[PTW-1], d_pterm} + (PTW+1)'(dterm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      d_v          <= dv[ND];
      result_valid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    result_tag <= d_tag;
    if (sum > (PTW+1)'(signed'(32'sh7fffffff))) begin
      steer_cmd <= 32'sh7fffffff;
    end else if (sum < (PTW+1)'(signed'(-33'sh080000000))) begin
      steer_cmd <= 32'sh80000000;
    end else begin
      steer_cmd <= sum[31:0];
    end
  end

  // every accepted request raises result_valid once it has passed the whole pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(ctsa_pkg::LATENCY + 1) result_valid)
    else $error("accepted request did not produce a result on time");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    sv[NQ] |-> (sroot[NQ][SQW-1:NW] == '0))
    else $error("norm exceeds its width");

  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    dv[ND] |-> (dq[ND] <= 17'd65536))
    else $error("sine magnitude above one");

endmodule
`default_nettype wire
